// File: rtl/core/bpc_pkg.sv
package bpc_pkg;

  // Field and datapath widths
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PRESS_W   = 32;
  localparam int TEMP_W    = 19;
  localparam int DT_W      = 25;   // D2 - C5*256
  localparam int MUL_W     = 42;   // dT times a calibration word
  localparam int DSQ_W     = 50;   // dT squared
  localparam int TM_W      = 18;   // TEMP - 2000
  localparam int TP_W      = 19;   // TEMP + 1500
  localparam int T2_W      = 18;
  localparam int SQR_W     = 35;   // squares of the temperature deltas
  localparam int WIDE_W    = 40;   // OFF, SENS and their corrections
  localparam int SPLIT_W   = 20;   // low slice of SENS in the pressure product
  localparam int PL_W      = 44;
  localparam int PH_W      = 45;
  localparam int PROD_W    = 64;
  localparam int DIFF_W    = 44;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;
  localparam logic signed [TEMP_W-1:0] TP_OFS    = 19'sd1500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coeff_t;

  // Item handed from the temperature section to the pressure section
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
    logic signed [TEMP_W-1:0] temp;
  } comp_item_t;

endpackage

// File: rtl/core/bpc_ifs.sv
// Raw reading pair channel
interface bpc_raw_if;
  import bpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// Compensated result channel
interface bpc_comp_if;
  import bpc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [PRESS_W-1:0] compensated_pressure;
  logic signed [TEMP_W-1:0]  compensated_temperature;

  modport source (output valid, output compensated_pressure,
                  output compensated_temperature, input ready);
  modport sink (input valid, input compensated_pressure,
                input compensated_temperature, output ready);
endinterface

// File: rtl/core/bpc_coeff_regs.sv
module bpc_coeff_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::COEF_W-1:0]     cfg_data,
  output bpc_pkg::coeff_t                coeff
);
  import bpc_pkg::*;

  // Calibration words; writes past the last index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_C1:  coeff.c1 <= cfg_data;
        REG_C2:  coeff.c2 <= cfg_data;
        REG_C3:  coeff.c3 <= cfg_data;
        REG_C4:  coeff.c4 <= cfg_data;
        REG_C5:  coeff.c5 <= cfg_data;
        REG_C6:  coeff.c6 <= cfg_data;
        default: coeff <= coeff;
      endcase
    end
  end

endmodule

// File: rtl/core/bpc_temp_pipe.sv
module bpc_temp_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  bpc_pkg::coeff_t            coeff,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bpc_pkg::RAW_W-1:0]  d1,
  input  logic [bpc_pkg::RAW_W-1:0]  d2,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bpc_pkg::comp_item_t        out_item
);
  import bpc_pkg::*;

  localparam int NS = 6;

  logic [NS:1]   v;
  logic [NS+1:1] rdy;
  logic [NS:0]   vin;
  logic [NS:1]   ld;

  // Stage registers
  logic        [RAW_W-1:0]  d1_1, d1_2, d1_3, d1_4, d1_5, d1_6;
  logic signed [DT_W-1:0]   dt_1;
  logic signed [MUL_W-1:0]  p6_2, p4_2, p3_2;
  logic signed [DSQ_W-1:0]  dsq_2;
  logic signed [TM_W-1:0]   tm_3;
  logic signed [TP_W-1:0]   tp_3;
  logic signed [TEMP_W-1:0] temp1_3, temp1_4, temp1_5, temp_6;
  logic signed [WIDE_W-1:0] off1_3, off1_4, off1_5, off_6;
  logic signed [WIDE_W-1:0] sens1_3, sens1_4, sens1_5, sens_6;
  logic        [T2_W-1:0]   t2_3, t2_4, t2_5;
  logic                     lo_3, lo_4, lo_5, vlo_3, vlo_4;
  logic        [SQR_W-1:0]  tm2_4, tp2_4;
  logic        [WIDE_W-1:0] off2_5, sens2_5;

  // Combinational helpers
  logic signed [TM_W-1:0]   tm_c;
  logic signed [TEMP_W-1:0] temp1_c;
  logic signed [TM_W*2-1:0] sq_tm;
  logic signed [TP_W*2-1:0] sq_tp;
  logic        [37:0]       five_c, seven_c;
  logic        [38:0]       eleven_c;

  // Flow control: a stage loads when empty or when its successor moves
  assign vin = {v, in_valid};
  always_comb begin
    rdy[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign ld = rdy[NS:1] & vin[NS-1:0];
  assign in_ready  = rdy[1];
  assign out_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) v[k] <= vin[k-1];
      end
    end
  end

  // Stage 1: dT = D2 - C5*256
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      d1_1 <= d1;
      dt_1 <= $signed({1'b0, d2}) - $signed({1'b0, coeff.c5, 8'h00});
    end
  end

  // Stage 2: products of dT with C6, C4, C3 and itself
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      d1_2  <= d1_1;
      p6_2  <= dt_1 * $signed({1'b0, coeff.c6});
      p4_2  <= dt_1 * $signed({1'b0, coeff.c4});
      p3_2  <= dt_1 * $signed({1'b0, coeff.c3});
      dsq_2 <= dt_1 * dt_1;
    end
  end

  // Stage 3: first-order TEMP, OFF, SENS and the low-temperature flags
  assign tm_c    = $signed(p6_2[40:23]);
  assign temp1_c = $signed({tm_c[TM_W-1], tm_c}) + TEMP_REF;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      d1_3    <= d1_2;
      tm_3    <= tm_c;
      temp1_3 <= temp1_c;
      tp_3    <= temp1_c + TP_OFS;
      lo_3    <= tm_c[TM_W-1];
      vlo_3   <= temp1_c < TEMP_VLOW;
      off1_3  <= $signed({8'd0, coeff.c2, 16'd0}) + $signed({{5{p4_2[41]}}, p4_2[41:7]});
      sens1_3 <= $signed({9'd0, coeff.c1, 15'd0}) + $signed({{6{p3_2[41]}}, p3_2[41:8]});
      t2_3    <= dsq_2[48:31];
    end
  end

  // Stage 4: squares of TEMP-2000 and TEMP+1500
  assign sq_tm = tm_3 * tm_3;
  assign sq_tp = tp_3 * tp_3;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      d1_4    <= d1_3;
      temp1_4 <= temp1_3;
      off1_4  <= off1_3;
      sens1_4 <= sens1_3;
      t2_4    <= t2_3;
      lo_4    <= lo_3;
      vlo_4   <= vlo_3;
      tm2_4   <= sq_tm[SQR_W-1:0];
      tp2_4   <= sq_tp[SQR_W-1:0];
    end
  end

  // Stage 5: second-order OFF2 and SENS2 (zero at 20 degC and above)
  assign five_c   = {1'b0, tm2_4, 2'b00} + {3'd0, tm2_4};
  assign seven_c  = {tp2_4, 3'd0} - {3'd0, tp2_4};
  assign eleven_c = {1'b0, tp2_4, 3'd0} + {3'd0, tp2_4, 1'b0} + {4'd0, tp2_4};

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      d1_5    <= d1_4;
      temp1_5 <= temp1_4;
      off1_5  <= off1_4;
      sens1_5 <= sens1_4;
      t2_5    <= t2_4;
      lo_5    <= lo_4;
      off2_5  <= lo_4 ? ({3'd0, five_c[37:1]} + (vlo_4 ? {2'd0, seven_c} : 40'd0)) : 40'd0;
      sens2_5 <= lo_4 ? ({4'd0, five_c[37:2]} + (vlo_4 ? {2'd0, eleven_c[38:1]} : 40'd0))
                      : 40'd0;
    end
  end

  // Stage 6: apply the corrections
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      d1_6   <= d1_5;
      off_6  <= off1_5 - $signed(off2_5);
      sens_6 <= sens1_5 - $signed(sens2_5);
      temp_6 <= lo_5 ? temp1_5 - $signed({1'b0, t2_5}) : temp1_5;
    end
  end

  assign out_item.d1   = d1_6;
  assign out_item.off  = off_6;
  assign out_item.sens = sens_6;
  assign out_item.temp = temp_6;

  // A stalled stage keeps its item
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v[3] && !rdy[3] |=> v[3] && $stable(temp1_3) && $stable(off1_3))
    else $error("stage 3 item changed while stalled");

  // Low-temperature flags agree with the first-order temperature
  a_flags: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> (lo_3 == (temp1_3 < TEMP_REF)) && (!vlo_3 || lo_3))
    else $error("low-temperature flags inconsistent");

  // No second-order correction at or above 20 degC
  a_no_corr: assert property (@(posedge clk) disable iff (rst)
    v[5] && !lo_5 |-> off2_5 == '0 && sens2_5 == '0)
    else $error("correction applied above 20 degC");

endmodule

// File: rtl/core/bpc_press_pipe.sv
module bpc_press_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bpc_pkg::comp_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpc_pkg::PRESS_W-1:0] pressure,
  output logic signed [bpc_pkg::TEMP_W-1:0]  temperature
);
  import bpc_pkg::*;

  localparam int NS = 3;

  logic [NS:1]   v;
  logic [NS+1:1] rdy;
  logic [NS:0]   vin;
  logic [NS:1]   ld;

  logic        [PL_W-1:0]   pl_1;
  logic signed [PH_W-1:0]   ph_1;
  logic signed [PROD_W-1:0] prod_2;
  logic signed [DIFF_W-1:0] x_3;
  logic signed [WIDE_W-1:0] off_1, off_2;
  logic signed [TEMP_W-1:0] temp_1, temp_2, temp_3;

  // Flow control, same scheme as the temperature section
  assign vin = {v, in_valid};
  always_comb begin
    rdy[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign ld = rdy[NS:1] & vin[NS-1:0];
  assign in_ready  = rdy[1];
  assign out_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) v[k] <= vin[k-1];
      end
    end
  end

  // Stage 1: D1*SENS as two partial products (low slice unsigned, high signed)
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      pl_1   <= in_item.d1 * in_item.sens[SPLIT_W-1:0];
      ph_1   <= $signed({1'b0, in_item.d1}) * $signed(in_item.sens[WIDE_W-1:SPLIT_W]);
      off_1  <= in_item.off;
      temp_1 <= in_item.temp;
    end
  end

  // Stage 2: recombine into the full product
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      prod_2 <= $signed({ph_1[PROD_W-SPLIT_W-1:0], 20'd0}) + $signed({20'd0, pl_1});
      off_2  <= off_1;
      temp_2 <= temp_1;
    end
  end

  // Stage 3: (D1*SENS >> 21) - OFF
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      x_3    <= $signed({prod_2[PROD_W-1], prod_2[PROD_W-1:21]})
              - $signed({{4{off_2[WIDE_W-1]}}, off_2});
      temp_3 <= temp_2;
    end
  end

  // Final >> 15; the result always lies well inside signed 32 bits
  assign pressure    = $signed({{3{x_3[DIFF_W-1]}}, x_3[DIFF_W-1:15]});
  assign temperature = temp_3;

  // Difference stays in range, so the pressure never needs clipping
  a_range: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> x_3[DIFF_W-1:41] == 3'b000 || x_3[DIFF_W-1:41] == 3'b111)
    else $error("pressure difference out of range");

  // A stalled partial product keeps its value
  a_pp_hold: assert property (@(posedge clk) disable iff (rst)
    v[1] && !rdy[1] |=> v[1] && $stable(ph_1) && $stable(pl_1))
    else $error("partial product changed while stalled");

endmodule

// File: rtl/core/baro_pressure_temp_compensation_top.sv
// Barometric pressure/temperature compensation with the second-order correction
// below 20.00 degC and the extra term below -15.00 degC. Each transfer on
// sample carries one raw pressure/temperature pair; result returns pressure in
// 0.01 mbar and temperature in 0.01 degC. The datapath is a nine-stage
// pipeline: one pair is accepted every cycle while the output is not held.
// The pressure product D1*SENS is formed as two 24x20 partial products and a
// 64-bit add, behind the six temperature stages. Stalls on result back up
// stage by stage; empty stages still take new pairs. The six calibration
// words are written through cfg_wr_en/cfg_index/cfg_data (index 0..5 =
// C1..C6, others ignored), clear to zero on reset, and may only change while
// no pair is in flight.
module baro_pressure_temp_compensation_top (
  input  logic                           clk,
  input  logic                           rst,
  bpc_raw_if.sink                        sample,
  bpc_comp_if.source                     result,
  input  logic                           cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::COEF_W-1:0]     cfg_data
);
  import bpc_pkg::*;

  coeff_t     coeff;
  logic       mid_valid;
  logic       mid_ready;
  comp_item_t mid_item;

  bpc_coeff_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff)
  );

  bpc_temp_pipe u_temp (
    .clk       (clk),
    .rst       (rst),
    .coeff     (coeff),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .d1        (sample.raw_pressure),
    .d2        (sample.raw_temperature),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_item  (mid_item)
  );

  bpc_press_pipe u_press (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mid_valid),
    .in_ready    (mid_ready),
    .in_item     (mid_item),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .pressure    (result.compensated_pressure),
    .temperature (result.compensated_temperature)
  );

endmodule

// File: tb/baro_pressure_temp_compensation_top_tb.sv
module baro_pressure_temp_compensation_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam int          NUM_WORDS   = 6;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int          DRAIN_WAIT  = 30;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;
  localparam logic [COEF_W-1:0] WORD_MAX = '1;
  // Indexes past the coefficient list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [PRESS_W-1:0] pressure;
    logic signed [TEMP_W-1:0]  temperature;
  } comp_reading_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  bpc_raw_if  sample_if ();
  bpc_comp_if result_if ();

  baro_pressure_temp_compensation_top u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_if),
    .result    (result_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Calibration words as the block should hold them
  logic [COEF_W-1:0] cal_word [NUM_WORDS];
  comp_reading_t     compensated_q [$];
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       tx_gap_pct;
  int unsigned       rx_stall_pct;
  int unsigned       rx_hold_cycles;
  int unsigned       rx_hold_seq;
  int unsigned       rx_hold_seen;
  int unsigned       rx_hold_left;
  int unsigned       rx_stall_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Second-order compensation of one raw pair with the current words
  function automatic comp_reading_t compensate(input logic [RAW_W-1:0] d1,
                                               input logic [RAW_W-1:0] d2);
    longint c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, tm, tp, off2, sens2, p;
    comp_reading_t r;
    c1 = longint'(cal_word[REG_C1]);
    c2 = longint'(cal_word[REG_C2]);
    c3 = longint'(cal_word[REG_C3]);
    c4 = longint'(cal_word[REG_C4]);
    c5 = longint'(cal_word[REG_C5]);
    c6 = longint'(cal_word[REG_C6]);
    dt   = longint'(d2) - c5 * 256;
    temp = longint'(TEMP_REF) + ((dt * c6) >>> 23);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    if (temp < longint'(TEMP_REF)) begin
      t2    = (dt * dt) >>> 31;
      tm    = temp - longint'(TEMP_REF);
      off2  = (5 * tm * tm) >>> 1;
      sens2 = (5 * tm * tm) >>> 2;
      // extra term in the very cold range
      if (temp < longint'(TEMP_VLOW)) begin
        tp    = temp + longint'(TP_OFS);
        off2  = off2 + 7 * tp * tp;
        sens2 = sens2 + ((11 * tp * tp) >>> 1);
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    if (p > longint'(32'sh7FFF_FFFF)) p = longint'(32'sh7FFF_FFFF);
    if (p < -longint'(64'sh8000_0000)) p = -longint'(64'sh8000_0000);
    r.pressure    = p[PRESS_W-1:0];
    r.temperature = temp[TEMP_W-1:0];
    return r;
  endfunction

  // Receiver: long hold on request, otherwise random stall bursts
  initial begin
    result_if.ready = 1'b0;
    rx_hold_seen    = 0;
    rx_hold_left    = 0;
    rx_stall_left   = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_seq != rx_hold_seen) begin
        rx_hold_seen = rx_hold_seq;
        rx_hold_left = rx_hold_cycles;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        result_if.ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        result_if.ready <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        rx_stall_left = $urandom_range(0, 5);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Result check against the oldest pending reading
  always @(posedge clk) begin
    comp_reading_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (compensated_q.size() == 0) begin
        $error("result transfer with no reading pair pending");
        fail_count++;
      end else begin
        want = compensated_q.pop_front();
        if (result_if.compensated_pressure !== want.pressure) begin
          $error("compensated_pressure: expected %0d, actual %0d",
                 want.pressure, result_if.compensated_pressure);
          fail_count++;
        end
        if (result_if.compensated_temperature !== want.temperature) begin
          $error("compensated_temperature: expected %0d, actual %0d",
                 want.temperature, result_if.compensated_temperature);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One raw pair, with an optional gap in front of it
  task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        sample_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    sample_if.valid           <= 1'b1;
    sample_if.raw_pressure    <= d1;
    sample_if.raw_temperature <= d2;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    compensated_q.push_back(compensate(d1, d2));
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    @(negedge clk);
    sample_if.valid <= 1'b0;
    while (compensated_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_word(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < NUM_WORDS) cal_word[idx] = val;
  endtask

  // Full coefficient set; only called with the pipeline empty
  task automatic load_words(input logic [COEF_W-1:0] w1, input logic [COEF_W-1:0] w2,
                            input logic [COEF_W-1:0] w3, input logic [COEF_W-1:0] w4,
                            input logic [COEF_W-1:0] w5, input logic [COEF_W-1:0] w6);
    write_word(REG_C1, w1);
    write_word(REG_C2, w2);
    write_word(REG_C3, w3);
    write_word(REG_C4, w4);
    write_word(REG_C5, w5);
    write_word(REG_C6, w6);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return WORD_MAX;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] random_pressure_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAW_MAX;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // Mostly uniform, some around the 20 degC knee, some at the rails
  function automatic logic [RAW_W-1:0] random_temperature_raw();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) != 0) ? RAW_MAX : '0;
      1, 2:    return RAW_W'((32'(cal_word[REG_C5]) << 8) + $urandom_range(0, 8192) - 4096);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // Coefficients at their reset value of zero
  task automatic test_reset_words();
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(24'h5A_A5C3, 24'h3C_0F96);
  endtask

  // Typical calibration; knee at 20 degC, cold and very cold branches
  task automatic test_typical_words();
    drain();
    load_words(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    // spare indexes must leave the words alone
    write_word(IDX_SPARE_LO, 16'hBEEF);
    write_word(IDX_SPARE_HI, 16'h1234);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    send_reading(24'd9085466, 24'd8569150);
    send_reading(24'd9085466, 24'd8566784);   // dT = 0, exactly 20.00 degC
    send_reading(24'd9085466, 24'd8566783);   // just below the knee
    send_reading(24'd9085466, 24'd7529784);   // near -15.00 degC
    send_reading(24'd9085466, 24'd7000000);   // very cold
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
  endtask

  // Coefficient rails with raw rails
  task automatic test_word_extremes();
    drain();
    load_words(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_reading('0, '0);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, RAW_MAX);
    drain();
    load_words(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '0, WORD_MAX);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading('0, RAW_MAX);
    drain();
    load_words('0, '0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_reading(RAW_MAX, '0);
    send_reading(RAW_MAX, RAW_MAX);
    drain();
    load_words(WORD_MAX, '0, '0, WORD_MAX, '0, '0);
    send_reading(RAW_MAX, RAW_MAX);
  endtask

  // Random calibrations, each with its own idling mix
  task automatic test_random_calibrations();
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      load_words(random_word(), random_word(), random_word(),
                 random_word(), random_word(), random_word());
      tx_gap_pct   = (ph == 3) ? 0 : $urandom_range(5, 40);
      rx_stall_pct = (ph == 3) ? 0 : $urandom_range(5, 40);
      repeat (225) send_reading(random_pressure_raw(), random_temperature_raw());
    end
  endtask

  // Output held off long enough for the pipeline to fill and stall its input
  task automatic test_output_backpressure();
    tx_gap_pct     = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 60;
    rx_hold_seq++;
    repeat (40) send_reading(random_pressure_raw(), random_temperature_raw());
  endtask

  // Sender pauses until the pipeline is empty, then resumes
  task automatic test_input_pause();
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    repeat (30) send_reading(random_pressure_raw(), random_temperature_raw());
    drain();
    repeat (30) send_reading(random_pressure_raw(), random_temperature_raw());
  endtask

  // Back-to-back transfers with no idling on either side
  task automatic test_full_rate();
    drain();
    load_words(random_word(), random_word(), random_word(),
               random_word(), random_word(), random_word());
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (150) send_reading(random_pressure_raw(), random_temperature_raw());
  endtask

  initial begin
    rst                       = 1'b1;
    cfg_wr_en                 = 1'b0;
    cfg_index                 = REG_C1;
    cfg_data                  = '0;
    sample_if.valid           = 1'b0;
    sample_if.raw_pressure    = '0;
    sample_if.raw_temperature = '0;
    tx_gap_pct                = 0;
    rx_stall_pct              = 0;
    rx_hold_cycles            = 0;
    rx_hold_seq               = 0;
    for (int i = 0; i < NUM_WORDS; i++) cal_word[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_words();
    tx_gap_pct   = 15;
    rx_stall_pct = 15;
    test_typical_words();
    test_word_extremes();
    test_random_calibrations();
    test_output_backpressure();
    test_input_pause();
    test_full_rate();

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && compensated_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_ifs.sv
rtl/core/bpc_coeff_regs.sv
rtl/core/bpc_temp_pipe.sv
rtl/core/bpc_press_pipe.sv
rtl/core/baro_pressure_temp_compensation_top.sv
tb/baro_pressure_temp_compensation_top_tb.sv
